FILE: hdl/lti_pkg.sv
// Shared constants and register index codes for the segment/triangle test.
package lti_pkg;

  localparam int NUM_AXES     = 3;
  localparam int AX_X         = 0;
  localparam int AX_Y         = 1;
  localparam int AX_Z         = 2;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } cfg_idx_t;

endpackage

FILE: hdl/line_triangle_intersection.sv
// Top level of the segment/triangle intersection pipeline with its segment registers.
// Throughput: one triangle per cycle while the output is not stalled;
// the depth comes from the divider, one quotient bit a stage.
// Reset (synchronous, active low) zeroes the segment registers and empties every stage.
module line_triangle_intersection #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [COORD_BITS-1:0]                in_vertex_a_x,
  input  logic [COORD_BITS-1:0]                in_vertex_a_y,
  input  logic [COORD_BITS-1:0]                in_vertex_a_z,
  input  logic [COORD_BITS-1:0]                in_vertex_b_x,
  input  logic [COORD_BITS-1:0]                in_vertex_b_y,
  input  logic [COORD_BITS-1:0]                in_vertex_b_z,
  input  logic [COORD_BITS-1:0]                in_vertex_c_x,
  input  logic [COORD_BITS-1:0]                in_vertex_c_y,
  input  logic [COORD_BITS-1:0]                in_vertex_c_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic [COORD_BITS-1:0]                out_hit_x,
  output logic [COORD_BITS-1:0]                out_hit_y,
  output logic [COORD_BITS-1:0]                out_hit_z,
  input  logic                                 cfg_we,
  input  logic [lti_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data
);

  localparam int DW   = COORD_BITS + 1;
  localparam int NW   = 2 * COORD_BITS + 3;
  localparam int AW   = 3 * COORD_BITS + 5;
  localparam int DENW = 3 * COORD_BITS + 6;
  // sideband that rides along the divider: a, b, normal, the ab/bc/ca edge vectors, dir signs, miss
  localparam int SBW  = 6 * COORD_BITS + 3 * NW + 9 * DW + 4;

  // segment endpoints; to be written only while the pipeline is empty, which the block does not enforce
  logic [2:0][COORD_BITS-1:0] start_r, end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_we) begin
      unique case (lti_pkg::cfg_idx_t'(cfg_index))
        lti_pkg::REG_START_X: start_r[lti_pkg::AX_X] <= cfg_data;
        lti_pkg::REG_START_Y: start_r[lti_pkg::AX_Y] <= cfg_data;
        lti_pkg::REG_START_Z: start_r[lti_pkg::AX_Z] <= cfg_data;
        lti_pkg::REG_END_X:   end_r[lti_pkg::AX_X]   <= cfg_data;
        lti_pkg::REG_END_Y:   end_r[lti_pkg::AX_Y]   <= cfg_data;
        lti_pkg::REG_END_Z:   end_r[lti_pkg::AX_Z]   <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  logic [2:0][COORD_BITS-1:0] va, vb, vc;
  assign va = {in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};
  assign vb = {in_vertex_b_z, in_vertex_b_y, in_vertex_b_x};
  assign vc = {in_vertex_c_z, in_vertex_c_y, in_vertex_c_x};

  // plane stage outputs
  logic                       pl_valid, pl_ready;
  logic [2:0][COORD_BITS-1:0] pl_va, pl_vb;
  logic [2:0][NW-1:0]         pl_n;
  logic [2:0][DW-1:0]         pl_ab, pl_bc, pl_ca, pl_dmag;
  logic [2:0]                 pl_dneg;
  logic [AW-1:0]              pl_d1mag;
  logic [DENW-1:0]            pl_den;
  logic                       pl_miss;

  lti_plane #(.COORD_BITS(COORD_BITS)) u_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_va     (va),
    .in_vb     (vb),
    .in_vc     (vc),
    .seg_start (start_r),
    .seg_end   (end_r),
    .out_valid (pl_valid),
    .out_ready (pl_ready),
    .out_va    (pl_va),
    .out_vb    (pl_vb),
    .out_n     (pl_n),
    .out_ab    (pl_ab),
    .out_bc    (pl_bc),
    .out_ca    (pl_ca),
    .out_dmag  (pl_dmag),
    .out_dneg  (pl_dneg),
    .out_d1mag (pl_d1mag),
    .out_den   (pl_den),
    .out_miss  (pl_miss)
  );

  // divider: offset magnitude per axis, sideband delayed alongside
  logic                       dv_valid, dv_ready;
  logic [SBW-1:0]             side_in, side_out;
  logic [2:0][DW-1:0]         dv_q;
  logic [2:0][COORD_BITS-1:0] dv_va, dv_vb;
  logic [2:0][NW-1:0]         dv_n;
  logic [2:0][DW-1:0]         dv_ab, dv_bc, dv_ca;
  logic [2:0]                 dv_dneg;
  logic                       dv_miss;

  assign side_in = {pl_va, pl_vb, pl_n, pl_ab, pl_bc, pl_ca, pl_dneg, pl_miss};
  assign {dv_va, dv_vb, dv_n, dv_ab, dv_bc, dv_ca, dv_dneg, dv_miss} = side_out;

  lti_div #(.COORD_BITS(COORD_BITS), .SBW(SBW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pl_valid),
    .in_ready  (pl_ready),
    .in_dmag   (pl_dmag),
    .in_d1mag  (pl_d1mag),
    .in_den    (pl_den),
    .in_side   (side_in),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_q     (dv_q),
    .out_side  (side_out)
  );

  // crossing point, edge tests and the result beat
  logic [2:0][COORD_BITS-1:0] hit_p;

  lti_edge #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_q      (dv_q),
    .in_dneg   (dv_dneg),
    .in_miss   (dv_miss),
    .in_va     (dv_va),
    .in_vb     (dv_vb),
    .in_n      (dv_n),
    .in_ab     (dv_ab),
    .in_bc     (dv_bc),
    .in_ca     (dv_ca),
    .seg_start (start_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit),
    .out_p     (hit_p)
  );

  assign out_hit_x = hit_p[lti_pkg::AX_X];
  assign out_hit_y = hit_p[lti_pkg::AX_Y];
  assign out_hit_z = hit_p[lti_pkg::AX_Z];

  // a miss beat carries a zero point
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_x == '0 && out_hit_y == '0 && out_hit_z == '0)
    else $error("miss beat with nonzero point");

  // a hit lies between the segment endpoints on x
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |->
      ($signed(out_hit_x) >= $signed(start_r[lti_pkg::AX_X]) &&
       $signed(out_hit_x) <= $signed(end_r[lti_pkg::AX_X])) ||
      ($signed(out_hit_x) <= $signed(start_r[lti_pkg::AX_X]) &&
       $signed(out_hit_x) >= $signed(end_r[lti_pkg::AX_X])))
    else $error("hit x outside segment");

  // a hit lies between the segment endpoints on z
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |->
      ($signed(out_hit_z) >= $signed(start_r[lti_pkg::AX_Z]) &&
       $signed(out_hit_z) <= $signed(end_r[lti_pkg::AX_Z])) ||
      ($signed(out_hit_z) <= $signed(start_r[lti_pkg::AX_Z]) &&
       $signed(out_hit_z) >= $signed(end_r[lti_pkg::AX_Z])))
    else $error("hit z outside segment");

  // input backpressure only when every stage is full, so a result must be waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with a bubble in the pipeline");

endmodule

FILE: hdl/lti_plane.sv
// Plane stages: edge vectors, triangle normal, endpoint distances, crossing classification.
module lti_plane #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0][COORD_BITS-1:0]          in_va,
  input  logic [2:0][COORD_BITS-1:0]          in_vb,
  input  logic [2:0][COORD_BITS-1:0]          in_vc,
  input  logic [2:0][COORD_BITS-1:0]          seg_start,
  input  logic [2:0][COORD_BITS-1:0]          seg_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0][COORD_BITS-1:0]          out_va,
  output logic [2:0][COORD_BITS-1:0]          out_vb,
  output logic [2:0][2*COORD_BITS+2:0]        out_n,
  output logic [2:0][COORD_BITS:0]            out_ab,
  output logic [2:0][COORD_BITS:0]            out_bc,
  output logic [2:0][COORD_BITS:0]            out_ca,
  output logic [2:0][COORD_BITS:0]            out_dmag,
  output logic [2:0]                          out_dneg,
  output logic [3*COORD_BITS+4:0]             out_d1mag,
  output logic [3*COORD_BITS+5:0]             out_den,
  output logic                                out_miss
);

  localparam int DW   = COORD_BITS + 1;
  localparam int NW   = 2 * COORD_BITS + 3;
  localparam int SW   = 3 * COORD_BITS + 6;
  localparam int AW   = 3 * COORD_BITS + 5;
  localparam int DENW = 3 * COORD_BITS + 6;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [2:0][COORD_BITS-1:0] va1_r, vb1_r, va2_r, vb2_r, va3_r, vb3_r;
  logic [2:0][DW-1:0] ab1_nxt, ac1_nxt, bc1_nxt, ca1_nxt, sa1_nxt, ea1_nxt, dir1_nxt;
  logic [2:0][DW-1:0] ab1_r, ac1_r, bc1_r, ca1_r, sa1_r, ea1_r, dir1_r;
  logic [2:0][DW-1:0] ab2_r, bc2_r, ca2_r, sa2_r, ea2_r, dir2_r;
  logic [2:0][DW-1:0] ab3_r, bc3_r, ca3_r, dir3_r;
  logic [2:0][NW-1:0] n2_nxt, n2_r, n3_r;
  logic signed [SW-1:0] d1_nxt, d2_nxt, d1_r, d2_r;
  logic d1_neg, d1_pos, d2_neg, d2_pos;
  logic [2:0][DW-1:0] dmag4_nxt;
  logic [2:0]         dneg4_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // edge and offset vectors, one bit wider than the coordinates
  always_comb begin
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      ab1_nxt[k]  = DW'($signed(in_vb[k])) - DW'($signed(in_va[k]));
      ac1_nxt[k]  = DW'($signed(in_vc[k])) - DW'($signed(in_va[k]));
      bc1_nxt[k]  = DW'($signed(in_vc[k])) - DW'($signed(in_vb[k]));
      ca1_nxt[k]  = DW'($signed(in_va[k])) - DW'($signed(in_vc[k]));
      sa1_nxt[k]  = DW'($signed(seg_start[k])) - DW'($signed(in_va[k]));
      ea1_nxt[k]  = DW'($signed(seg_end[k])) - DW'($signed(in_va[k]));
      dir1_nxt[k] = DW'($signed(seg_end[k])) - DW'($signed(seg_start[k]));
    end
  end

  // normal = ab x ac
  always_comb begin
    n2_nxt[lti_pkg::AX_X] =
      NW'($signed(ab1_r[lti_pkg::AX_Y])) * NW'($signed(ac1_r[lti_pkg::AX_Z])) -
      NW'($signed(ab1_r[lti_pkg::AX_Z])) * NW'($signed(ac1_r[lti_pkg::AX_Y]));
    n2_nxt[lti_pkg::AX_Y] =
      NW'($signed(ab1_r[lti_pkg::AX_Z])) * NW'($signed(ac1_r[lti_pkg::AX_X])) -
      NW'($signed(ab1_r[lti_pkg::AX_X])) * NW'($signed(ac1_r[lti_pkg::AX_Z]));
    n2_nxt[lti_pkg::AX_Z] =
      NW'($signed(ab1_r[lti_pkg::AX_X])) * NW'($signed(ac1_r[lti_pkg::AX_Y])) -
      NW'($signed(ab1_r[lti_pkg::AX_Y])) * NW'($signed(ac1_r[lti_pkg::AX_X]));
  end

  // signed plane distances of both endpoints
  always_comb begin
    d1_nxt = '0;
    d2_nxt = '0;
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      d1_nxt = d1_nxt + SW'($signed(sa2_r[k])) * SW'($signed(n2_r[k]));
      d2_nxt = d2_nxt + SW'($signed(ea2_r[k])) * SW'($signed(n2_r[k]));
    end
  end

  assign d1_neg = d1_r[SW-1];
  assign d2_neg = d2_r[SW-1];
  assign d1_pos = !d1_neg && (d1_r != '0);
  assign d2_pos = !d2_neg && (d2_r != '0);

  always_comb begin
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      dneg4_nxt[k] = dir3_r[k][DW-1];
      dmag4_nxt[k] = dneg4_nxt[k] ? DW'(-$signed(dir3_r[k])) : dir3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      va1_r  <= in_va;
      vb1_r  <= in_vb;
      ab1_r  <= ab1_nxt;
      ac1_r  <= ac1_nxt;
      bc1_r  <= bc1_nxt;
      ca1_r  <= ca1_nxt;
      sa1_r  <= sa1_nxt;
      ea1_r  <= ea1_nxt;
      dir1_r <= dir1_nxt;
    end
    if (rdy2) begin
      va2_r  <= va1_r;
      vb2_r  <= vb1_r;
      ab2_r  <= ab1_r;
      bc2_r  <= bc1_r;
      ca2_r  <= ca1_r;
      sa2_r  <= sa1_r;
      ea2_r  <= ea1_r;
      dir2_r <= dir1_r;
      n2_r   <= n2_nxt;
    end
    if (rdy3) begin
      va3_r  <= va2_r;
      vb3_r  <= vb2_r;
      ab3_r  <= ab2_r;
      bc3_r  <= bc2_r;
      ca3_r  <= ca2_r;
      dir3_r <= dir2_r;
      n3_r   <= n2_r;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
    end
    if (rdy4) begin
      out_va    <= va3_r;
      out_vb    <= vb3_r;
      out_ab    <= ab3_r;
      out_bc    <= bc3_r;
      out_ca    <= ca3_r;
      out_n     <= n3_r;
      out_dmag  <= dmag4_nxt;
      out_dneg  <= dneg4_nxt;
      out_d1mag <= AW'(d1_neg ? -d1_r : d1_r);
      out_den   <= DENW'(d1_neg ? d2_r - d1_r : d1_r - d2_r);
      out_miss  <= !((d1_neg && d2_pos) || (d1_pos && d2_neg));
    end
  end

  assign out_valid = v4_r;

endmodule

FILE: hdl/lti_div.sv
// Crossing offset: split multiply, then one restoring quotient bit per stage on each axis.
module lti_div #(
  parameter int COORD_BITS = 16,
  parameter int SBW        = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][COORD_BITS:0]      in_dmag,
  input  logic [3*COORD_BITS+4:0]       in_d1mag,
  input  logic [3*COORD_BITS+5:0]       in_den,
  input  logic [SBW-1:0]                in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][COORD_BITS:0]      out_q,
  output logic [SBW-1:0]                out_side
);

  localparam int DW   = COORD_BITS + 1;
  localparam int AW   = 3 * COORD_BITS + 5;
  localparam int DENW = 3 * COORD_BITS + 6;
  localparam int Q    = COORD_BITS + 1;
  localparam int H    = (AW + 1) / 2;
  localparam int LOW  = DW + H;
  localparam int HIW  = DW + AW - H;
  localparam int NUMW = DW + AW;

  logic                m1v_r, rdy_m1;
  logic [2:0][LOW-1:0] plo_nxt, plo_r;
  logic [2:0][HIW-1:0] phi_nxt, phi_r;
  logic [DENW-1:0]     den1_r;
  logic [SBW-1:0]      side1_r;
  logic [2:0][NUMW-1:0] num_nxt;

  logic                  dv_r   [Q+1];
  logic [Q:0]            rdy;
  logic [2:0][DENW-1:0]  rem_r  [Q+1];
  logic [2:0][Q-1:0]     low_r  [Q+1];
  logic [2:0][Q-1:0]     quo_r  [Q+1];
  logic [DENW-1:0]       den_r  [Q+1];
  logic [SBW-1:0]        side_r [Q+1];
  logic [2:0][DENW:0]    trial  [Q];
  logic [2:0]            ge     [Q];
  logic [2:0][DENW-1:0]  rem_nxt [Q];

  always_comb begin
    rdy[Q] = !dv_r[Q] || out_ready;
    for (int j = Q - 1; j >= 0; j--) begin
      rdy[j] = !dv_r[j] || rdy[j+1];
    end
  end
  assign rdy_m1   = !m1v_r || rdy[0];
  assign in_ready = rdy_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
      for (int j = 0; j <= Q; j++) dv_r[j] <= 1'b0;
    end else begin
      if (rdy_m1) m1v_r <= in_valid;
      if (rdy[0]) dv_r[0] <= m1v_r;
      for (int j = 1; j <= Q; j++) begin
        if (rdy[j]) dv_r[j] <= dv_r[j-1];
      end
    end
  end

  // numerator |dir| * |d1| in two partial products, summed one stage later
  always_comb begin
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      plo_nxt[k] = LOW'(in_dmag[k]) * LOW'(in_d1mag[H-1:0]);
      phi_nxt[k] = HIW'(in_dmag[k]) * HIW'(in_d1mag[AW-1:H]);
      num_nxt[k] = NUMW'(plo_r[k]) + (NUMW'(phi_r[k]) << H);
    end
  end

  // trial subtract of the divisor, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < Q; j++) begin
      for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
        trial[j][k]   = {rem_r[j][k], low_r[j][k][Q-1]};
        ge[j][k]      = trial[j][k] >= {1'b0, den_r[j]};
        rem_nxt[j][k] = ge[j][k] ? DENW'(trial[j][k] - {1'b0, den_r[j]})
                                 : DENW'(trial[j][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m1) begin
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      den1_r  <= in_den;
      side1_r <= in_side;
    end
    if (rdy[0]) begin
      for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
        rem_r[0][k] <= DENW'(num_nxt[k][NUMW-1:Q]);
        low_r[0][k] <= num_nxt[k][Q-1:0];
        quo_r[0][k] <= '0;
      end
      den_r[0]  <= den1_r;
      side_r[0] <= side1_r;
    end
    for (int j = 0; j < Q; j++) begin
      if (rdy[j+1]) begin
        for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
          rem_r[j+1][k] <= rem_nxt[j][k];
          low_r[j+1][k] <= low_r[j][k] << 1;
          quo_r[j+1][k] <= {quo_r[j][k][Q-2:0], ge[j][k]};
        end
        den_r[j+1]  <= den_r[j];
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = dv_r[Q];
  assign out_q     = quo_r[Q];
  assign out_side  = side_r[Q];

endmodule

FILE: hdl/lti_edge.sv
// Crossing point, the edge-side tests for ab, bc and ca, and the result register.
module lti_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][COORD_BITS:0]      in_q,
  input  logic [2:0]                    in_dneg,
  input  logic                          in_miss,
  input  logic [2:0][COORD_BITS-1:0]    in_va,
  input  logic [2:0][COORD_BITS-1:0]    in_vb,
  input  logic [2:0][2*COORD_BITS+2:0]  in_n,
  input  logic [2:0][COORD_BITS:0]      in_ab,
  input  logic [2:0][COORD_BITS:0]      in_bc,
  input  logic [2:0][COORD_BITS:0]      in_ca,
  input  logic [2:0][COORD_BITS-1:0]    seg_start,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [2:0][COORD_BITS-1:0]    out_p
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = COORD_BITS + 2;
  localparam int NW = 2 * COORD_BITS + 3;
  localparam int TW = 4 * COORD_BITS + 8;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [2:0][COORD_BITS-1:0] p1_nxt, p1_r, p2_r, p3_r, p4_r;
  logic [2:0][COORD_BITS-1:0] va1_r, vb1_r;
  logic [2:0][NW-1:0]         n1_r, n2_r, n3_r;
  logic [2:0][DW-1:0]         ab1_r, bc1_r, ca1_r;
  logic                       miss1_r, miss2_r, miss3_r, miss4_r;
  logic [2:0][2:0][DW-1:0]    ed2_nxt, rel2_nxt, ed2_r, rel2_r;
  logic [2:0][2:0][NW-1:0]    w3_nxt, w3_r;
  logic signed [TW-1:0]       dot4 [3];
  logic [2:0]                 ok4_nxt, ok4_r;
  logic                       hit5_nxt;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // point = start +/- truncated offset
  always_comb begin
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      p1_nxt[k] = COORD_BITS'(PW'($signed(seg_start[k])) +
                              (in_dneg[k] ? -PW'(in_q[k]) : PW'(in_q[k])));
    end
  end

  // edge e runs from its base; ca is based at a like ab
  always_comb begin
    ed2_nxt[0] = ab1_r;
    ed2_nxt[1] = bc1_r;
    ed2_nxt[2] = ca1_r;
    for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
      rel2_nxt[0][k] = DW'($signed(p1_r[k])) - DW'($signed(va1_r[k]));
      rel2_nxt[1][k] = DW'($signed(p1_r[k])) - DW'($signed(vb1_r[k]));
      rel2_nxt[2][k] = DW'($signed(p1_r[k])) - DW'($signed(va1_r[k]));
    end
  end

  // (n x ed) . rel is evaluated as n . (ed x rel)
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      w3_nxt[e][lti_pkg::AX_X] =
        NW'($signed(ed2_r[e][lti_pkg::AX_Y])) * NW'($signed(rel2_r[e][lti_pkg::AX_Z])) -
        NW'($signed(ed2_r[e][lti_pkg::AX_Z])) * NW'($signed(rel2_r[e][lti_pkg::AX_Y]));
      w3_nxt[e][lti_pkg::AX_Y] =
        NW'($signed(ed2_r[e][lti_pkg::AX_Z])) * NW'($signed(rel2_r[e][lti_pkg::AX_X])) -
        NW'($signed(ed2_r[e][lti_pkg::AX_X])) * NW'($signed(rel2_r[e][lti_pkg::AX_Z]));
      w3_nxt[e][lti_pkg::AX_Z] =
        NW'($signed(ed2_r[e][lti_pkg::AX_X])) * NW'($signed(rel2_r[e][lti_pkg::AX_Y])) -
        NW'($signed(ed2_r[e][lti_pkg::AX_Y])) * NW'($signed(rel2_r[e][lti_pkg::AX_X]));
    end
  end

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      dot4[e] = '0;
      for (int k = 0; k < lti_pkg::NUM_AXES; k++) begin
        dot4[e] = dot4[e] + TW'($signed(n3_r[k])) * TW'($signed(w3_r[e][k]));
      end
      ok4_nxt[e] = !dot4[e][TW-1];
    end
  end

  assign hit5_nxt = !miss4_r && (&ok4_r);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_r    <= p1_nxt;
      va1_r   <= in_va;
      vb1_r   <= in_vb;
      n1_r    <= in_n;
      ab1_r   <= in_ab;
      bc1_r   <= in_bc;
      ca1_r   <= in_ca;
      miss1_r <= in_miss;
    end
    if (rdy2) begin
      p2_r    <= p1_r;
      n2_r    <= n1_r;
      miss2_r <= miss1_r;
      ed2_r   <= ed2_nxt;
      rel2_r  <= rel2_nxt;
    end
    if (rdy3) begin
      p3_r    <= p2_r;
      n3_r    <= n2_r;
      miss3_r <= miss2_r;
      w3_r    <= w3_nxt;
    end
    if (rdy4) begin
      p4_r    <= p3_r;
      miss4_r <= miss3_r;
      ok4_r   <= ok4_nxt;
    end
    if (rdy5) begin
      out_hit <= hit5_nxt;
      out_p   <= hit5_nxt ? p4_r : '0;
    end
  end

  assign out_valid = v5_r;

endmodule
